>>> sv/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, register indexes and reset values of the PID step core.
// ----------------------------------------------------------------------------
`default_nettype none
package pfd_pkg;
  localparam int DataW   = 32;  // error, gains, drive
  localparam int DtW     = 24;  // time step, Q0.24
  localparam int SlopeW  = 48;  // smoothed derivative
  localparam int MulAW   = 49;  // multiplicand width of the shared multiplier
  localparam int MulBW   = 33;  // multiplier width (signed)
  localparam int ProdW   = MulAW + MulBW;
  localparam int NumW    = 56;  // dividend width, |diff| << 24
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_OUT_LIMIT   = 3'd3,
    REG_SMOOTH      = 3'd4
  } cfg_reg_t;

  localparam logic [30:0] OutLimitReset = 31'h7FFF_FFFF;
  localparam logic [15:0] SmoothReset   = 16'd6554;
endpackage
`default_nettype wire

>>> sv/pfd_mul.sv
// ----------------------------------------------------------------------------
// pfd_mul
// Shared shift-add multiplier: signed 49 x signed 33 bits, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfd_mul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [pfd_pkg::MulAW-1:0]    a,
  input  wire logic signed [pfd_pkg::MulBW-1:0]    b,
  output logic                                     done,
  output logic signed [pfd_pkg::ProdW-1:0]         product
);
  localparam logic [5:0] LastBit = 6'(pfd_pkg::MulBW - 1);

  logic                               busy;
  logic [5:0]                         cnt;
  logic signed [pfd_pkg::ProdW-1:0]   acc;
  logic signed [pfd_pkg::ProdW-1:0]   mcand;
  logic [pfd_pkg::MulBW-1:0]          mplier;
  logic signed [pfd_pkg::ProdW-1:0]   addend;

  // Sign bit of the multiplier carries negative weight
  always_comb begin
    if (!mplier[0]) begin
      addend = '0;
    end else if (cnt == LastBit) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
  end

  // Step one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == LastBit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= pfd_pkg::ProdW'(a);
      mplier <= b;
    end else if (busy) begin
      acc    <= acc + addend;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;
endmodule
`default_nettype wire

>>> sv/pfd_div.sv
// ----------------------------------------------------------------------------
// pfd_div
// Restoring divider: unsigned 56-bit dividend by 24-bit divisor, a bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfd_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pfd_pkg::NumW-1:0]      num,
  input  wire logic [pfd_pkg::DtW-1:0]       den,
  output logic                               done,
  output logic [pfd_pkg::NumW-1:0]           quot
);
  localparam logic [5:0] LastStep = 6'(pfd_pkg::NumW - 1);

  logic                          busy;
  logic [5:0]                    cnt;
  logic [pfd_pkg::DtW-1:0]       rem;
  logic [pfd_pkg::DtW-1:0]       dreg;
  logic [pfd_pkg::NumW-1:0]      nshift;
  logic [pfd_pkg::DtW+1:0]       trial;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem, nshift[pfd_pkg::NumW-1]} - {2'b00, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restore when the trial goes negative
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      dreg   <= den;
      nshift <= num;
      quot   <= '0;
    end else if (busy) begin
      nshift <= nshift << 1;
      if (trial[pfd_pkg::DtW+1]) begin
        rem  <= {rem[pfd_pkg::DtW-2:0], nshift[pfd_pkg::NumW-1]};
        quot <= {quot[pfd_pkg::NumW-2:0], 1'b0};
      end else begin
        rem  <= trial[pfd_pkg::DtW-1:0];
        quot <= {quot[pfd_pkg::NumW-2:0], 1'b1};
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/pid_filtered_derivative_core.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative_core
// PID step with clamped integral and exponentially smoothed derivative.
// ----------------------------------------------------------------------------
// Sequence: a compute item takes six passes of the shared multiplier and one of
//   the divider, which a zero time step skips; a clear item only resets state.
//   A new item is accepted only in S_IDLE, once the previous result has been
//   loaded into the result register.
// Reset: synchronous, clears controller state, loads register defaults.
`default_nettype none
module pid_filtered_derivative_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // [31:0] error, [55:32] time_step
  input  wire logic        s_axis_tuser,  // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] drive
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [pfd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_INTEG, S_DIV, S_SM_OLD, S_SM_RAW, S_PROP, S_INT_T, S_DER, S_OUT
  } state_t;

  state_t state;
  logic   launch;

  // Registers
  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic [30:0]        output_limit;
  logic [15:0]        smooth_factor;

  // Controller state and work registers
  logic signed [31:0]                 integral_sum, last_error, err_q;
  logic signed [pfd_pkg::SlopeW-1:0]  smoothed_slope, raw;
  logic                               primed;
  logic [pfd_pkg::DtW-1:0]            dt_q;
  logic signed [pfd_pkg::ProdW-1:0]   sm_acc, sum_acc;

  // Shared units
  logic signed [pfd_pkg::MulAW-1:0]   mul_a;
  logic signed [pfd_pkg::MulBW-1:0]   mul_b;
  logic                               mul_done, div_done;
  logic signed [pfd_pkg::ProdW-1:0]   prod;
  logic [pfd_pkg::NumW-1:0]           div_num, quot;

  logic signed [32:0] diff;
  logic [31:0]        abs_diff;
  logic signed [33:0] isum, ilim, iclamp;
  logic signed [pfd_pkg::ProdW-1:0]   sm_total, sum_total;
  logic signed [65:0] sh, lim, y;
  logic signed [pfd_pkg::SlopeW-1:0]  raw_next;

  logic in_xfer;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // Operand selection for the multiplier
  always_comb begin
    case (state)
      S_INTEG: begin
        mul_a = pfd_pkg::MulAW'(err_q);
        mul_b = pfd_pkg::MulBW'({1'b0, dt_q});
      end
      S_SM_OLD: begin
        mul_a = pfd_pkg::MulAW'(smoothed_slope);
        mul_b = pfd_pkg::MulBW'({1'b0, smooth_factor});
      end
      S_SM_RAW: begin
        mul_a = pfd_pkg::MulAW'(raw);
        mul_b = pfd_pkg::MulBW'(17'h10000 - {1'b0, smooth_factor});
      end
      S_PROP: begin
        mul_a = pfd_pkg::MulAW'(err_q);
        mul_b = pfd_pkg::MulBW'(prop_gain);
      end
      S_INT_T: begin
        mul_a = pfd_pkg::MulAW'(integral_sum);
        mul_b = pfd_pkg::MulBW'(integ_gain);
      end
      S_DER: begin
        mul_a = pfd_pkg::MulAW'(smoothed_slope);
        mul_b = pfd_pkg::MulBW'(deriv_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Integral update and clamp
  always_comb begin
    isum = 34'(integral_sum) + $signed(prod[57:24]);
    ilim = $signed({4'b0000, output_limit[30:1]});
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  // Slope magnitude, quotient sign and saturation
  always_comb begin
    diff     = 33'(err_q) - 33'(last_error);
    abs_diff = diff[32] ? 32'(-diff) : diff[31:0];
    div_num  = {abs_diff, 24'd0};
    if (diff[32]) begin
      raw_next = (quot > 56'h0000_8000_0000_0000) ? 48'sh8000_0000_0000
                                                   : -$signed(quot[47:0]);
    end else begin
      raw_next = (quot > 56'h0000_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                                   : $signed(quot[47:0]);
    end
  end

  // Sums and output clamp
  always_comb begin
    sm_total  = sm_acc + prod;
    sum_total = sum_acc + prod;
    sh        = sum_acc[pfd_pkg::ProdW-1:16];
    lim       = $signed({35'd0, output_limit});
    if (sh > lim) begin
      y = lim;
    end else if (sh < -lim) begin
      y = -lim;
    end else begin
      y = sh;
    end
  end

  pfd_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (launch && (state != S_DIV)),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  pfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (launch && (state == S_DIV)),
    .num   (div_num),
    .den   (dt_q),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      launch         <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      output_limit   <= pfd_pkg::OutLimitReset;
      smooth_factor  <= pfd_pkg::SmoothReset;
      integral_sum   <= '0;
      last_error     <= '0;
      smoothed_slope <= '0;
      primed         <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // Register writes
      if (cfg_valid) begin
        case (cfg_index)
          pfd_pkg::REG_PROP_GAIN:  prop_gain     <= $signed(cfg_data);
          pfd_pkg::REG_INTEG_GAIN: integ_gain    <= $signed(cfg_data);
          pfd_pkg::REG_DERIV_GAIN: deriv_gain    <= $signed(cfg_data);
          pfd_pkg::REG_OUT_LIMIT:  output_limit  <= cfg_data[30:0];
          pfd_pkg::REG_SMOOTH:     smooth_factor <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser) begin
              integral_sum   <= '0;
              last_error     <= '0;
              smoothed_slope <= '0;
              primed         <= 1'b0;
            end else begin
              err_q  <= $signed(s_axis_tdata[31:0]);
              dt_q   <= s_axis_tdata[55:32];
              if (!primed) begin
                last_error <= $signed(s_axis_tdata[31:0]);
                primed     <= 1'b1;
              end
              state  <= S_INTEG;
              launch <= 1'b1;
            end
          end
        end
        S_INTEG: begin
          if (mul_done) begin
            integral_sum <= iclamp[31:0];
            launch       <= 1'b1;
            if (dt_q == '0) begin
              raw   <= '0;
              state <= S_SM_OLD;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            raw    <= raw_next;
            state  <= S_SM_OLD;
            launch <= 1'b1;
          end
        end
        S_SM_OLD: begin
          if (mul_done) begin
            sm_acc <= prod;
            state  <= S_SM_RAW;
            launch <= 1'b1;
          end
        end
        S_SM_RAW: begin
          if (mul_done) begin
            smoothed_slope <= sm_total[63:16];
            last_error     <= err_q;
            state          <= S_PROP;
            launch         <= 1'b1;
          end
        end
        S_PROP: begin
          if (mul_done) begin
            sum_acc <= prod;
            state   <= S_INT_T;
            launch  <= 1'b1;
          end
        end
        S_INT_T: begin
          if (mul_done) begin
            sum_acc <= sum_total;
            state   <= S_DER;
            launch  <= 1'b1;
          end
        end
        S_DER: begin
          if (mul_done) begin
            sum_acc <= sum_total;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the result register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= y[31:0];
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level assertions for the PID step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  // Reset drops any pending result
  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input closes right after a compute transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input ready right after transfer");

  // No result appears the cycle after an input transfer
  a_no_fast: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");
endmodule

bind pid_filtered_derivative_core pfd_checker u_pfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/sv/tb_pid_filtered_derivative_core.sv
// ----------------------------------------------------------------------------
// tb_pid_filtered_derivative_core
// Streams compute and clear items through the PID step core under several
// register settings, predicts each drive value with a bit-exact fixed-point
// model and checks every result transfer in order, with random bursts, gaps
// and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

class pid_drive_board;
  // register copies
  longint kp, ki, kd, lim, alpha;
  // controller state
  longint integ, prev_err, slope;
  bit primed;
  longint drive_q[$];
  int mismatches;

  function new();
    kp = 0;
    ki = 0;
    kd = 0;
    lim = 64'h7FFF_FFFF;
    alpha = 6554;
    integ = 0;
    prev_err = 0;
    slope = 0;
    primed = 0;
    mismatches = 0;
  endfunction

  function void write_reg(pfd_pkg::cfg_reg_t idx, logic [31:0] val);
    case (idx)
      pfd_pkg::REG_PROP_GAIN:  kp = longint'(signed'(val));
      pfd_pkg::REG_INTEG_GAIN: ki = longint'(signed'(val));
      pfd_pkg::REG_DERIV_GAIN: kd = longint'(signed'(val));
      pfd_pkg::REG_OUT_LIMIT:  lim = longint'(val[30:0]);
      pfd_pkg::REG_SMOOTH:     alpha = longint'(val[15:0]);
      default: ;
    endcase
  endfunction

  function longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // note one accepted input transfer
  function void note_item(bit clear_op, logic [31:0] err_bits, logic [23:0] dt_bits);
    longint e, dt, ilim, diff, raw, dterm, y;
    logic signed [127:0] total, prod;
    logic [63:0] mag;
    if (clear_op) begin
      integ = 0;
      prev_err = 0;
      slope = 0;
      primed = 0;
      return;
    end
    e = longint'(signed'(err_bits));
    dt = longint'(dt_bits);
    if (!primed) begin
      prev_err = e;
      primed = 1;
    end
    ilim = lim >>> 1;
    integ = clip(integ + ((e * dt) >>> 24), -ilim, ilim);
    raw = 0;
    if (dt != 0) begin
      diff = e - prev_err;
      mag = (diff < 0 ? -diff : diff);
      mag = (mag << 24) / dt;
      raw = diff < 0 ? -longint'(mag) : longint'(mag);
      raw = clip(raw, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    end
    slope = (alpha * slope + (65536 - alpha) * raw) >>> 16;
    prev_err = e;
    // exact sum; int64 saturation of the derivative term cannot change
    // the clamped drive, so a wide sum is equivalent
    prod = 128'(kd) * 128'(slope);
    total = 128'(kp * e) + 128'(ki * integ) + prod;
    total = total >>> 16;
    if (total > 128'(lim)) y = lim;
    else if (total < -128'(lim)) y = -lim;
    else y = longint'(total);
    drive_q.push_back(y);
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_drive(logic [31:0] got);
    logic [31:0] want;
    if (drive_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected drive %h", got);
      return;
    end
    want = 32'(drive_q.pop_front());
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("drive mismatch: expected %h got %h", want, got);
    end
  endfunction
endclass

module tb_pid_filtered_derivative_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // [31:0] error, [55:32] time_step
  logic        s_axis_tuser;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] drive
  logic        cfg_valid;
  logic        cfg_ready;
  logic [pfd_pkg::CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;

  localparam bit OP_COMPUTE = 1'b0;
  localparam bit OP_CLEAR   = 1'b1;

  pid_drive_board board;
  int burst_left;
  bit stall_mode;

  pid_filtered_derivative_core uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

  // receiver: stalls in alternating quiet and busy stretches
  initial begin
    m_axis_tready = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) board.check_drive(m_axis_tdata);
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic write_reg(pfd_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_item(bit op, logic [31:0] err, logic [23:0] dt);
    int gap;
    // sender gaps between bursts; valid stays high within a burst
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 300);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {dt, err};
    do @(posedge clk); while (!s_axis_tready);
    board.note_item(op, err, dt);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.drive_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_err();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 8;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic logic [23:0] rand_dt();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'($urandom_range(1, 16));
      2: return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] errs [6];
    board = new();
    burst_left = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    cfg_valid = 0;
    cfg_index = pfd_pkg::REG_PROP_GAIN;
    cfg_data = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset gains: output stays zero
    send_item(OP_COMPUTE, 32'h0001_0000, 24'h10_0000);
    drain();
    write_reg(pfd_pkg::REG_PROP_GAIN, 32'h0001_0000);
    write_reg(pfd_pkg::REG_INTEG_GAIN, 32'h0000_8000);
    write_reg(pfd_pkg::REG_DERIV_GAIN, 32'h0000_0100);
    // directed: field extremes, zero step, clear, seeding
    errs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
             32'hFFFF_0000};
    foreach (errs[i]) send_item(OP_COMPUTE, errs[i], 24'h00_0001);
    send_item(OP_COMPUTE, 32'h0010_0000, 24'd0);
    send_item(OP_COMPUTE, 32'h8000_0000, 24'hFF_FFFF);
    send_item(OP_COMPUTE, 32'h7FFF_FFFF, 24'h80_0000);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_item(OP_COMPUTE, 32'h0002_0000, 24'h00_4000);
    send_item(OP_COMPUTE, 32'h0000_0000, 24'h00_4000);
    drain();
    // extremes of every register, zero limit
    write_reg(pfd_pkg::REG_OUT_LIMIT, 32'h0);
    write_reg(pfd_pkg::REG_SMOOTH, 32'h0);
    send_item(OP_COMPUTE, 32'h0005_0000, 24'h01_0000);
    send_item(OP_COMPUTE, 32'h8000_0000, 24'h00_0001);
    drain();
    write_reg(pfd_pkg::REG_PROP_GAIN, 32'h8000_0000);
    write_reg(pfd_pkg::REG_INTEG_GAIN, 32'h7FFF_FFFF);
    write_reg(pfd_pkg::REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(pfd_pkg::REG_OUT_LIMIT, 32'hFFFF_FFFF);
    write_reg(pfd_pkg::REG_SMOOTH, 32'hFFFF);
    send_item(OP_COMPUTE, 32'h7FFF_FFFF, 24'h00_0001);
    send_item(OP_COMPUTE, 32'h8000_0000, 24'h00_0001);
    send_item(OP_COMPUTE, 32'h1234_5678, 24'hFF_FFFF);
    drain();

    // random phases with new settings between them
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(pfd_pkg::REG_PROP_GAIN, phase == 6 ? 32'h7FFF_FFFF : rand_err());
      write_reg(pfd_pkg::REG_INTEG_GAIN, rand_err());
      write_reg(pfd_pkg::REG_DERIV_GAIN, phase == 6 ? 32'h7FFF_FFFF : rand_err());
      write_reg(pfd_pkg::REG_OUT_LIMIT,
                phase[0] ? $urandom : 32'($urandom_range(0, 32'h00FF_FFFF)));
      write_reg(pfd_pkg::REG_SMOOTH, phase == 5 ? 32'h0 : $urandom);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 19) == 0) send_item(OP_CLEAR, $urandom, 24'($urandom));
        else send_item(OP_COMPUTE, rand_err(), rand_dt());
      end
      drain();
    end

    if (board.mismatches == 0 && board.drive_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> filelist.f
sv/pfd_pkg.sv
sv/pfd_mul.sv
sv/pfd_div.sv
sv/pid_filtered_derivative_core.sv
sv/pfd_checker.sv
tb/sv/tb_pid_filtered_derivative_core.sv
